// ----- hdl/byte_stream_tokenizer_unit_defines.svh -----
// Assertion helpers for the tokenizer. Both forms share the same ports so that
// a synthesis build can drop the checks by defining SYNTH.
`ifndef BYTE_STREAM_TOKENIZER_UNIT_DEFINES_SVH
`define BYTE_STREAM_TOKENIZER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define BST_ASSERT_IMPLIES(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);
`define BST_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);
`else
`define BST_ASSERT_IMPLIES(label, clk, rst, cond, prop, msg)
`define BST_ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif

`endif

// ----- hdl/bst_pkg.sv -----
package bst_pkg;

  localparam int KIND_W   = 6;
  localparam int NUM_KW   = 11;
  localparam int KW_BITS  = 48;

  typedef enum logic [KIND_W-1:0] {
    KIND_LPAREN  = 6'd0,
    KIND_RPAREN  = 6'd1,
    KIND_LBRACK  = 6'd2,
    KIND_RBRACK  = 6'd3,
    KIND_LBRACE  = 6'd4,
    KIND_RBRACE  = 6'd5,
    KIND_COMMA   = 6'd6,
    KIND_SEMI    = 6'd7,
    KIND_DOT     = 6'd8,
    KIND_COLON   = 6'd9,
    KIND_PLUS    = 6'd10,
    KIND_MINUS   = 6'd11,
    KIND_STAR    = 6'd12,
    KIND_SLASH   = 6'd13,
    KIND_ASSIGN  = 6'd14,
    KIND_EQ      = 6'd15,
    KIND_BANG    = 6'd16,
    KIND_NE      = 6'd17,
    KIND_LT      = 6'd18,
    KIND_SHL     = 6'd19,
    KIND_GT      = 6'd20,
    KIND_SHR     = 6'd21,
    KIND_STRING  = 6'd22,
    KIND_NUMBER  = 6'd23,
    KIND_NAME    = 6'd24,
    KIND_LET     = 6'd25,
    KIND_IF      = 6'd26,
    KIND_ELSE    = 6'd27,
    KIND_FOR     = 6'd28,
    KIND_WHILE   = 6'd29,
    KIND_AND     = 6'd30,
    KIND_OR      = 6'd31,
    KIND_TRUE    = 6'd32,
    KIND_FALSE   = 6'd33,
    KIND_FN      = 6'd34,
    KIND_RETURN  = 6'd35,
    KIND_END     = 6'd36,
    KIND_ERROR   = 6'd37
  } kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_OP      = 3'd1,
    MODE_COMMENT = 3'd2,
    MODE_STRING  = 3'd3,
    MODE_ESCAPE  = 3'd4,
    MODE_NUMBER  = 3'd5,
    MODE_NAME    = 3'd6
  } mode_t;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // Keyword text with the first character in the low byte, zero padded.
  localparam logic [KW_BITS-1:0] KW_TEXT [NUM_KW] = '{
    48'h0000_0074_656C,  // let
    48'h0000_0000_6669,  // if
    48'h0000_6573_6C65,  // else
    48'h0000_0072_6F66,  // for
    48'h0065_6C69_6877,  // while
    48'h0000_0064_6E61,  // and
    48'h0000_0000_726F,  // or
    48'h0000_6575_7274,  // true
    48'h0065_736C_6166,  // false
    48'h0000_0000_6E66,  // fn
    48'h6E72_7574_6572   // return
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd3, 3'd2, 3'd4, 3'd3, 3'd5, 3'd3, 3'd2, 3'd4, 3'd5, 3'd2, 3'd6
  };

  function automatic logic digit_byte(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic letter_byte(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == "_");
  endfunction

  // Kind of a pending operator character, single or doubled form.
  function automatic kind_t op_kind(input logic [7:0] op, input logic dbl);
    kind_t k;
    case (op)
      "/":     k = KIND_SLASH;
      "=":     k = dbl ? KIND_EQ  : KIND_ASSIGN;
      "!":     k = dbl ? KIND_NE  : KIND_BANG;
      "<":     k = dbl ? KIND_SHL : KIND_LT;
      default: k = dbl ? KIND_SHR : KIND_GT;
    endcase
    return k;
  endfunction

  // Second character that turns a pending operator into its two-character form.
  function automatic logic [7:0] op_pair(input logic [7:0] op);
    return ((op == "=") || (op == "!")) ? 8'("=") : op;
  endfunction

endpackage

// ----- hdl/bst_if.sv -----
interface bst_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_input;

  modport source (output valid, output source_byte, output end_of_input, input ready);
  modport sink   (input valid, input source_byte, input end_of_input, output ready);
endinterface

interface bst_token_if #(
  parameter int OFFSET_BITS = 20
);
  logic                        valid;
  logic                        ready;
  logic [bst_pkg::KIND_W-1:0]  token_kind;
  logic [OFFSET_BITS-1:0]      token_start;
  logic [OFFSET_BITS-1:0]      token_length;
  logic [OFFSET_BITS-1:0]      line_number;
  logic                        last_of_run;

  modport source (output valid, output token_kind, output token_start, output token_length,
                  output line_number, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_start, input token_length,
                  input line_number, input last_of_run, output ready);
endinterface

// ----- hdl/bst_token_queue.sv -----
module bst_token_queue #(
  parameter int W     = 68,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [1:0]   push_cnt,
  input  logic [W-1:0] push0,
  input  logic [W-1:0] push1,
  output logic         room,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  // Two free entries are kept so that any beat can be taken without a stall check.
  assign room      = (count <= CNT_W'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem[PTR_W'(wr_ptr + 1'b1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= PTR_W'(wr_ptr + PTR_W'(push_cnt));
      rd_ptr <= PTR_W'(rd_ptr + PTR_W'(pop));
      count  <= CNT_W'(count + CNT_W'(push_cnt) - CNT_W'(pop));
    end
  end
endmodule

// ----- hdl/byte_stream_tokenizer_unit.sv -----
// Streaming tokenizer: one source byte per input beat, tokens out with kind, start offset,
// length and line. A byte is taken in every cycle while the four-entry token queue has two
// free entries; its tokens are registered in the queue. A byte that yields one token or
// none keeps a rate of one byte per cycle while the queue has room; a byte that closes a
// token and also makes its own (two tokens) pushes both at once, so sustained throughput is
// one token per cycle while the receiver is ready, set by the single output port draining
// the queue. After end of input, an unterminated string or an unexpected byte the block
// halts and consumes further beats without producing tokens until reset.
`include "byte_stream_tokenizer_unit_defines.svh"

module byte_stream_tokenizer_unit #(
  parameter int OFFSET_BITS       = 20,
  parameter int KEYWORD_MAX_CHARS = 6
) (
  input  logic         clk,
  input  logic         rst,
  bst_byte_if.sink     byte_in,
  bst_token_if.source  token_out
);
  import bst_pkg::*;

  localparam int OB     = OFFSET_BITS;
  localparam int PRE_W  = 8 * KEYWORD_MAX_CHARS;
  localparam int REC_W  = KIND_W + 3 * OB + 1;

  mode_t             mode, mode_next;
  logic [7:0]        pend_op, pend_op_next;
  logic [PRE_W-1:0]  name_prefix, name_prefix_next;
  logic [OB-1:0]     tok_begin, tok_begin_next;
  logic [OB-1:0]     pos, pos_next;
  logic [OB-1:0]     line, line_next;
  logic [OB-1:0]     run_len, run_len_next;
  logic              seen_dot, seen_dot_next;
  logic              halted, halted_next;

  logic              fire;
  logic [7:0]        b;
  logic              again;
  logic              close_v, own_v;
  kind_t             close_kind, own_kind;
  logic [OB-1:0]     close_start, own_start;
  logic [OB-1:0]     close_len, own_len;
  logic [1:0]        push_cnt;
  logic [REC_W-1:0]  close_rec, own_rec;
  logic [REC_W-1:0]  push0;
  logic [REC_W-1:0]  head;
  logic              room;

  function automatic logic [OB-1:0] sat_inc(input logic [OB-1:0] v);
    return (v == '1) ? v : OB'(v + 1'b1);
  endfunction

  function automatic kind_t name_kind(input logic [PRE_W-1:0] pre, input logic [OB-1:0] len);
    kind_t k;
    k = KIND_NAME;
    for (int i = 0; i < NUM_KW; i++) begin
      if ((len == OB'(KW_LEN[i])) && (pre[KW_BITS-1:0] == KW_TEXT[i])) begin
        k = kind_t'(KIND_W'(KIND_LET) + KIND_W'(i));
      end
    end
    return k;
  endfunction

  assign fire          = byte_in.valid && byte_in.ready;
  assign b             = byte_in.source_byte;
  assign byte_in.ready = room;

  always_comb begin
    mode_next        = mode;
    pend_op_next     = pend_op;
    name_prefix_next = name_prefix;
    tok_begin_next   = tok_begin;
    pos_next         = pos;
    line_next        = line;
    run_len_next     = run_len;
    seen_dot_next    = seen_dot;
    halted_next      = halted;
    again            = 1'b0;
    close_v          = 1'b0;
    close_kind       = KIND_END;
    close_start      = tok_begin;
    close_len        = run_len;
    own_v            = 1'b0;
    own_kind         = KIND_END;
    own_start        = pos;
    own_len          = '0;

    if (fire && !halted) begin
      if (byte_in.end_of_input) begin
        unique case (mode) inside
          MODE_OP: begin
            close_v    = 1'b1;
            close_kind = op_kind(pend_op, 1'b0);
            close_len  = OB'(1);
          end
          MODE_NUMBER: begin
            close_v    = 1'b1;
            close_kind = KIND_NUMBER;
          end
          MODE_NAME: begin
            close_v    = 1'b1;
            close_kind = name_kind(name_prefix, run_len);
          end
          MODE_STRING, MODE_ESCAPE: begin
            close_v    = 1'b1;
            close_kind = KIND_ERROR;
          end
          default: ;
        endcase
        // An unterminated string reports only the error, no end token.
        own_v       = !((mode == MODE_STRING) || (mode == MODE_ESCAPE));
        halted_next = 1'b1;
        mode_next   = MODE_IDLE;
      end else begin
        unique case (mode) inside
          MODE_OP: begin
            mode_next = MODE_IDLE;
            if ((pend_op == "/") && (b == "/")) begin
              mode_next = MODE_COMMENT;
            end else if ((pend_op != "/") && (b == op_pair(pend_op))) begin
              close_v    = 1'b1;
              close_kind = op_kind(pend_op, 1'b1);
              close_len  = OB'(2);
            end else begin
              close_v    = 1'b1;
              close_kind = op_kind(pend_op, 1'b0);
              close_len  = OB'(1);
              again      = 1'b1;
            end
          end
          MODE_COMMENT: begin
            if (b == CH_LF) begin
              line_next = sat_inc(line);
              mode_next = MODE_IDLE;
            end
          end
          MODE_STRING: begin
            if (b == CH_QUOTE) begin
              close_v    = 1'b1;
              close_kind = KIND_STRING;
              mode_next  = MODE_IDLE;
            end else begin
              if (b == CH_BSLASH) begin
                mode_next = MODE_ESCAPE;
              end
              run_len_next = sat_inc(run_len);
            end
          end
          MODE_ESCAPE: begin
            run_len_next = sat_inc(run_len);
            mode_next    = MODE_STRING;
          end
          MODE_NUMBER: begin
            if (digit_byte(b) || ((b == ".") && !seen_dot)) begin
              if (b == ".") begin
                seen_dot_next = 1'b1;
              end
              run_len_next = sat_inc(run_len);
            end else begin
              close_v    = 1'b1;
              close_kind = KIND_NUMBER;
              mode_next  = MODE_IDLE;
              again      = 1'b1;
            end
          end
          MODE_NAME: begin
            if (digit_byte(b) || letter_byte(b)) begin
              for (int i = 0; i < KEYWORD_MAX_CHARS; i++) begin
                if (run_len == OB'(i)) begin
                  name_prefix_next[8*i +: 8] = b;
                end
              end
              run_len_next = sat_inc(run_len);
            end else begin
              close_v    = 1'b1;
              close_kind = name_kind(name_prefix, run_len);
              mode_next  = MODE_IDLE;
              again      = 1'b1;
            end
          end
          default: begin
            mode_next = MODE_IDLE;
            again     = 1'b1;
          end
        endcase

        // The byte starts afresh: either the lexer was idle or it just closed a token.
        if (again) begin
          own_start = pos;
          own_len   = OB'(1);
          case (b) inside
            "(": begin own_v = 1'b1; own_kind = KIND_LPAREN; end
            ")": begin own_v = 1'b1; own_kind = KIND_RPAREN; end
            "[": begin own_v = 1'b1; own_kind = KIND_LBRACK; end
            "]": begin own_v = 1'b1; own_kind = KIND_RBRACK; end
            "{": begin own_v = 1'b1; own_kind = KIND_LBRACE; end
            "}": begin own_v = 1'b1; own_kind = KIND_RBRACE; end
            ",": begin own_v = 1'b1; own_kind = KIND_COMMA; end
            ";": begin own_v = 1'b1; own_kind = KIND_SEMI; end
            ".": begin own_v = 1'b1; own_kind = KIND_DOT; end
            ":": begin own_v = 1'b1; own_kind = KIND_COLON; end
            "+": begin own_v = 1'b1; own_kind = KIND_PLUS; end
            "-": begin own_v = 1'b1; own_kind = KIND_MINUS; end
            "*": begin own_v = 1'b1; own_kind = KIND_STAR; end
            "/", "=", "!", "<", ">": begin
              mode_next      = MODE_OP;
              pend_op_next   = b;
              tok_begin_next = pos;
            end
            " ", CH_CR, CH_TAB: ;
            CH_LF: begin
              line_next = sat_inc(line);
            end
            CH_QUOTE: begin
              mode_next      = MODE_STRING;
              tok_begin_next = OB'(pos + 1'b1);
              run_len_next   = '0;
            end
            ["0":"9"]: begin
              mode_next      = MODE_NUMBER;
              tok_begin_next = pos;
              run_len_next   = OB'(1);
              seen_dot_next  = 1'b0;
            end
            ["a":"z"], ["A":"Z"], "_": begin
              mode_next        = MODE_NAME;
              tok_begin_next   = pos;
              run_len_next     = OB'(1);
              name_prefix_next = PRE_W'(b);
            end
            default: begin
              own_v       = 1'b1;
              own_kind    = KIND_ERROR;
              halted_next = 1'b1;
            end
          endcase
        end
        pos_next = OB'(pos + 1'b1);
      end
    end
  end

  // Every token carries the line as it stood before this byte.
  assign close_rec = {close_kind, close_start, close_len, line, !own_v};
  assign own_rec   = {own_kind, own_start, own_len, line, 1'b1};
  assign push_cnt  = 2'(close_v) + 2'(own_v);
  assign push0     = close_v ? close_rec : own_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      pend_op     <= '0;
      name_prefix <= '0;
      tok_begin   <= '0;
      pos         <= '0;
      line        <= OB'(1);
      run_len     <= '0;
      seen_dot    <= 1'b0;
      halted      <= 1'b0;
    end else begin
      mode        <= mode_next;
      pend_op     <= pend_op_next;
      name_prefix <= name_prefix_next;
      tok_begin   <= tok_begin_next;
      pos         <= pos_next;
      line        <= line_next;
      run_len     <= run_len_next;
      seen_dot    <= seen_dot_next;
      halted      <= halted_next;
    end
  end

  bst_token_queue #(
    .W     (REC_W),
    .DEPTH (4)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (push_cnt),
    .push0     (push0),
    .push1     (own_rec),
    .room      (room),
    .out_valid (token_out.valid),
    .out_ready (token_out.ready),
    .out_data  (head)
  );

  assign token_out.token_kind   = head[REC_W-1 -: KIND_W];
  assign token_out.token_start  = head[3*OB : 2*OB+1];
  assign token_out.token_length = head[2*OB : OB+1];
  assign token_out.line_number  = head[OB : 1];
  assign token_out.last_of_run  = head[0];

  `BST_ASSERT_IMPLIES(a_halted_quiet, clk, rst, halted, push_cnt == 2'd0, "token after halt")
  `BST_ASSERT_NEXT(a_end_halts, clk, rst, fire && byte_in.end_of_input, halted, "end did not halt")
  `BST_ASSERT_NEXT(a_halt_sticky, clk, rst, halted, halted && (pos == $past(pos)), "halt released")
endmodule
